FILE: src/beep_pattern_sequencer_defines.svh
// Assertion macros for the beep pattern sequencer port checker.
// No dependencies; the user supplies a clock i_clk and reset i_rst_n in scope.
`ifndef BEEP_PATTERN_SEQUENCER_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bps_pkg.sv
// Types, codes and helpers for the beep pattern sequencer.
// No dependencies.
package bps_pkg;

    localparam int TICK_WIDTH = 24;
    localparam int REG_WIDTH  = 24;
    localparam int IDX_WIDTH  = 2;

    localparam logic [63:0] TICK_MAX = (64'd1 << TICK_WIDTH) - 64'd1;

    typedef logic [TICK_WIDTH-1:0] t_ticks;
    typedef logic [REG_WIDTH-1:0]  t_reg;

    localparam logic [2:0] PAT_OFF    = 3'd0;
    localparam logic [2:0] PAT_SHORT  = 3'd1;
    localparam logic [2:0] PAT_LONG   = 3'd2;
    localparam logic [2:0] PAT_TWICE  = 3'd3;
    localparam logic [2:0] PAT_THRICE = 3'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [IDX_WIDTH-1:0] CFG_SHORT = 2'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_LONG  = 2'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_GAP   = 2'd2;

    localparam t_reg RST_SHORT = 24'd100;
    localparam t_reg RST_LONG  = 24'd500;
    localparam t_reg RST_GAP   = 24'd100;

    typedef struct packed {
        t_reg short_ticks;
        t_reg long_ticks;
        t_reg gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic finished;
        logic busy;
        logic buzzer;
    } t_result;

    // Saturate a register length to the counter width
    function automatic t_ticks load_len(input t_reg v);
        logic [63:0] w;
        w = 64'(v);
        if (w > TICK_MAX) begin
            return t_ticks'(TICK_MAX);
        end
        return t_ticks'(w);
    endfunction

endpackage

FILE: src/bps_seq.sv
// Pattern state and next-state logic of the beep pattern sequencer.
// Depends on bps_pkg.
module bps_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_command,
    input  logic [2:0]      i_pattern,
    input  bps_pkg::t_cfg   i_cfg,
    output bps_pkg::t_result o_result
);

    logic [2:0]      r_pattern, n_pattern;
    logic [2:0]      r_phase,   n_phase;
    bps_pkg::t_ticks r_ticks,   n_ticks;
    logic            r_tone,    n_tone;
    logic            fin;
    logic [2:0]      last;

    always_comb begin
        n_pattern = r_pattern;
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_tone    = r_tone;
        fin       = 1'b0;
        case (r_pattern)
            bps_pkg::PAT_TWICE:  last = 3'd2;
            bps_pkg::PAT_THRICE: last = 3'd4;
            default:             last = 3'd0;
        endcase
        if (i_command == bps_pkg::CMD_START) begin
            n_pattern = bps_pkg::PAT_OFF;
            n_phase   = 3'd0;
            n_ticks   = '0;
            n_tone    = 1'b0;
            if (i_pattern >= bps_pkg::PAT_SHORT && i_pattern <= bps_pkg::PAT_THRICE) begin
                n_pattern = i_pattern;
                n_tone    = 1'b1;
                n_ticks   = bps_pkg::load_len((i_pattern == bps_pkg::PAT_LONG)
                                              ? i_cfg.long_ticks : i_cfg.short_ticks);
            end
        end else if (r_pattern != bps_pkg::PAT_OFF) begin
            if (r_ticks <= bps_pkg::t_ticks'(1)) begin
                if (r_phase >= last) begin
                    n_pattern = bps_pkg::PAT_OFF;
                    n_phase   = 3'd0;
                    n_ticks   = '0;
                    n_tone    = 1'b0;
                    fin       = 1'b1;
                end else begin
                    n_phase = r_phase + 3'd1;
                    if (n_phase[0]) begin
                        n_tone  = 1'b0;
                        n_ticks = bps_pkg::load_len(i_cfg.gap_ticks);
                    end else begin
                        n_tone  = 1'b1;
                        n_ticks = bps_pkg::load_len(i_cfg.short_ticks);
                    end
                end
            end else begin
                n_ticks = r_ticks - bps_pkg::t_ticks'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= bps_pkg::PAT_OFF;
            r_phase   <= 3'd0;
            r_ticks   <= '0;
            r_tone    <= 1'b0;
        end else if (i_accept) begin
            r_pattern <= n_pattern;
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_tone    <= n_tone;
        end
    end

    assign o_result.buzzer   = n_tone;
    assign o_result.busy     = (n_pattern != bps_pkg::PAT_OFF);
    assign o_result.finished = fin;

endmodule

FILE: src/beep_pattern_sequencer.sv
// Top level of the beep pattern sequencer: configuration, stream ports, output register.
// Depends on bps_pkg and bps_seq.
//
// At most one item is taken per clock cycle. Each transfer on the input stream (a tick or
// a start) yields exactly one result, which is registered in the output register and holds
// there until taken. The input is ready whenever that register is empty or being emptied
// in the same cycle, so a sink that always takes results sustains one item per cycle; the
// single output register sets that figure. The user must write the length registers
// through the plain write port only while the block is idle; not enforced by the block.
module beep_pattern_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bps_pkg::IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [bps_pkg::REG_WIDTH-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [2:0] pattern, [7:3] zero
    input  logic                          s_axis_tuser,  // [0] command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata   // [0] buzzer_enable, [1] busy_res,
                                                         // [2] finished, [7:3] zero
);

    bps_pkg::t_cfg    r_cfg;
    bps_pkg::t_result res;
    bps_pkg::t_result r_res;
    logic             r_m_valid;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks <= bps_pkg::RST_SHORT;
            r_cfg.long_ticks  <= bps_pkg::RST_LONG;
            r_cfg.gap_ticks   <= bps_pkg::RST_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bps_pkg::CFG_SHORT: r_cfg.short_ticks <= i_cfg_data;
                bps_pkg::CFG_LONG:  r_cfg.long_ticks  <= i_cfg_data;
                bps_pkg::CFG_GAP:   r_cfg.gap_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bps_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (s_axis_tuser),
        .i_pattern (s_axis_tdata[2:0]),
        .i_cfg     (r_cfg),
        .o_result  (res)
    );

    // Hold the result until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b0, r_res.finished, r_res.busy, r_res.buzzer};

endmodule

FILE: src/bps_checker.sv
// Port-level checks for the beep pattern sequencer, bound to the top level.
// Depends on bps_pkg and beep_pattern_sequencer_defines.svh.
`include "beep_pattern_sequencer_defines.svh"

module bps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic       in_xfer;
    logic [2:0] in_pattern;
    logic       start_beep;
    logic       out_tone;
    logic       out_busy;
    logic       out_fin;
    logic       out_stall;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign in_pattern = s_axis_tdata[2:0];
    assign start_beep = in_xfer && (s_axis_tuser == bps_pkg::CMD_START)
                        && (in_pattern >= bps_pkg::PAT_SHORT)
                        && (in_pattern <= bps_pkg::PAT_THRICE);

    assign out_tone  = m_axis_tdata[0];
    assign out_busy  = m_axis_tdata[1];
    assign out_fin   = m_axis_tdata[2];
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `BPS_ASSERT_NOW(a_fin_idle, m_axis_tvalid && out_fin, !out_busy && !out_tone, "finished while busy")
    `BPS_ASSERT_NOW(a_tone_busy, m_axis_tvalid && out_tone, out_busy, "buzzer on outside a pattern")
    `BPS_ASSERT_NEXT(a_start_sounds, start_beep, m_axis_tvalid && out_tone && out_busy && !out_fin, "start silent")
    `BPS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/beep_pattern_sequencer_check.sv
`timescale 1ns / 1ps
// Checker for the beep pattern sequencer: follows the length writes and both stream channels,
// predicts each result from its own copy of the pattern state and compares in order.
// Depends on bps_pkg.
module beep_pattern_sequencer_check
    import bps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_WIDTH-1:0] i_cfg_idx,
    input  t_reg                 i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [2:0] pattern, [7:3] zero
    input  logic                 s_axis_tuser,   // [0] command
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,   // [0] buzzer_enable, [1] busy_res,
                                                 // [2] finished, [7:3] zero
    output int                   o_fail_count,
    output int                   o_pending
);

    t_cfg       lengths;
    logic [2:0] run_pattern;
    logic [2:0] run_phase;
    t_ticks     ticks_left;
    logic       tone;
    t_result    due_results[$];

    function automatic t_ticks to_count(input t_reg v);
        return (64'(v) > TICK_MAX) ? t_ticks'(TICK_MAX) : t_ticks'(v);
    endfunction

    task automatic silence();
        run_pattern = PAT_OFF;
        run_phase   = '0;
        ticks_left  = '0;
        tone        = 1'b0;
    endtask

    task automatic step_sequencer(input logic cmd, input logic [2:0] pat, output t_result res);
        logic [2:0] last_phase;
        logic       done;
        done = 1'b0;
        if (cmd == CMD_START) begin
            silence();
            if (pat >= PAT_SHORT && pat <= PAT_THRICE) begin
                run_pattern = pat;
                tone        = 1'b1;
                ticks_left  = to_count((pat == PAT_LONG) ? lengths.long_ticks
                                                         : lengths.short_ticks);
            end
        end else if (run_pattern != PAT_OFF) begin
            if (ticks_left <= t_ticks'(1)) begin
                ticks_left = '0;
                case (run_pattern)
                    PAT_TWICE:  last_phase = 3'd2;
                    PAT_THRICE: last_phase = 3'd4;
                    default:    last_phase = 3'd0;
                endcase
                if (run_phase >= last_phase) begin
                    silence();
                    done = 1'b1;
                end else begin
                    run_phase = run_phase + 3'd1;
                    if (run_phase[0]) begin
                        tone       = 1'b0;
                        ticks_left = to_count(lengths.gap_ticks);
                    end else begin
                        tone       = 1'b1;
                        ticks_left = to_count(lengths.short_ticks);
                    end
                end
            end else begin
                ticks_left = ticks_left - t_ticks'(1);
            end
        end
        res.buzzer   = tone;
        res.busy     = (run_pattern != PAT_OFF);
        res.finished = done;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            lengths      = '{short_ticks: RST_SHORT, long_ticks: RST_LONG, gap_ticks: RST_GAP};
            silence();
            due_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHORT: lengths.short_ticks = i_cfg_data;
                    CFG_LONG:  lengths.long_ticks  = i_cfg_data;
                    CFG_GAP:   lengths.gap_ticks   = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                step_sequencer(s_axis_tuser, s_axis_tdata[2:0], want);
                due_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[2:0]);
                if (due_results.size() == 0) begin
                    $error("unexpected result transfer: tdata %h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.buzzer !== want.buzzer) begin
                        $error("buzzer_enable: expected %b, got %b", want.buzzer, got.buzzer);
                        o_fail_count++;
                    end
                    if (got.busy !== want.busy) begin
                        $error("busy_res: expected %b, got %b", want.busy, got.busy);
                        o_fail_count++;
                    end
                    if (got.finished !== want.finished) begin
                        $error("finished: expected %b, got %b", want.finished, got.finished);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[7:3] !== 5'd0) begin
                        $error("tdata padding: expected %h, got %h", 5'd0, m_axis_tdata[7:3]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

FILE: dv/beep_pattern_sequencer_test.sv
`timescale 1ns / 1ps
// Top of the beep pattern sequencer test: clock, reset, length writes, tick and start
// stimulus with bursty source and stalling sink, and the verdict.
// Depends on bps_pkg, beep_pattern_sequencer and beep_pattern_sequencer_check.
module beep_pattern_sequencer_test;
    import bps_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_WIDTH-1:0] i_cfg_idx;
    t_reg                 i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    int         fail_count;
    int         pending;
    int         n_sent  = 0;
    int         n_taken = 0;
    int         burst_left = 0;
    int         gap_max = 0;
    t_cfg       written;
    logic [9:0] sink_cyc = '0;

    localparam t_reg LEN_MAX = '1;

    beep_pattern_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    beep_pattern_sequencer_check i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            n_sent <= n_sent + 1;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            n_taken <= n_taken + 1;
        end
    end

    // Sink stall pattern: free running, light random, one in eight, coin toss
    always @(posedge i_clk) begin
        sink_cyc <= sink_cyc + 10'd1;
        case (sink_cyc[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= (sink_cyc[2:0] == 3'd7);
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic write_lengths(input t_reg short_len, input t_reg long_len, input t_reg gap_len);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SHORT;
        i_cfg_data <= short_len;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG;
        i_cfg_data <= long_len;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GAP;
        i_cfg_data <= gap_len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        written = '{short_ticks: short_len, long_ticks: long_len, gap_ticks: gap_len};
    endtask

    task automatic send(input logic cmd, input logic [2:0] pat);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, pat};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic tick();
        send(CMD_TICK, 3'($urandom_range(0, 7)));
    endtask

    // Hold the source until every result is back, then let the block settle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_taken != n_sent);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int span(input t_reg v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int pattern_span(input logic [2:0] pat);
        int total;
        total = span((pat == PAT_LONG) ? written.long_ticks : written.short_ticks);
        if (pat == PAT_TWICE) begin
            total += span(written.gap_ticks) + span(written.short_ticks);
        end else if (pat == PAT_THRICE) begin
            total += 2 * (span(written.gap_ticks) + span(written.short_ticks));
        end
        return total;
    endfunction

    initial begin : stimulus
        int         done;
        int         need;
        int         ticks;
        logic [2:0] pat;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SHORT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        written = '{short_ticks: RST_SHORT, long_ticks: RST_LONG, gap_ticks: RST_GAP};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset lengths: idle tick, off and undefined codes, aborts
        gap_max = 3;
        send(CMD_TICK, PAT_OFF);
        send(CMD_START, PAT_OFF);
        for (int k = 1; k <= 3; k++) begin
            send(CMD_START, 3'(PAT_THRICE + k));
        end
        send(CMD_START, PAT_SHORT);
        send(CMD_TICK, 3'(PAT_THRICE + 3));
        send(CMD_START, PAT_LONG);
        send(CMD_TICK, PAT_OFF);
        send(CMD_START, PAT_OFF);
        send(CMD_TICK, PAT_SHORT);
        settle();

        // Short lengths: every pattern runs to its end
        write_lengths(t_reg'(1), t_reg'(2), t_reg'(1));
        send(CMD_START, PAT_THRICE);
        repeat (5) send(CMD_TICK, PAT_OFF);
        send(CMD_START, PAT_TWICE);
        repeat (3) send(CMD_TICK, PAT_OFF);
        send(CMD_START, PAT_LONG);
        repeat (2) send(CMD_TICK, PAT_OFF);
        send(CMD_START, PAT_SHORT);
        send(CMD_TICK, PAT_OFF);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_lengths('0, '0, '0);
                1: write_lengths(LEN_MAX, LEN_MAX, LEN_MAX);
                2: write_lengths(t_reg'(1), t_reg'(1), t_reg'(1));
                3: write_lengths(t_reg'(2), LEN_MAX, t_reg'(1));
                4: write_lengths(t_reg'($urandom_range(1, 60)), t_reg'($urandom_range(1, 60)),
                                 t_reg'($urandom_range(1, 60)));
                default: write_lengths(t_reg'($urandom_range(1, 8)),
                                       t_reg'($urandom_range(1, 8)),
                                       t_reg'($urandom_range(1, 8)));
            endcase
            gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 2 : 6);
            burst_left = 0;
            done = 0;
            while (done < 112) begin
                if ($urandom_range(0, 9) < 8) begin
                    pat  = 3'($urandom_range(PAT_SHORT, PAT_THRICE));
                    need = pattern_span(pat);
                    if (need > 300) begin
                        ticks = $urandom_range(1, 300);
                    end else if ($urandom_range(0, 3) == 0) begin
                        ticks = $urandom_range(0, need - 1);
                    end else begin
                        ticks = need + $urandom_range(0, 2);
                    end
                    send(CMD_START, pat);
                    repeat (ticks) tick();
                    done += 1 + ticks;
                end else begin
                    send(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
                    done++;
                end
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("beep_pattern_sequencer test passed");
        end else begin
            $display("beep_pattern_sequencer test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("beep_pattern_sequencer test failed");
        $finish;
    end

endmodule

FILE: beep_pattern_sequencer.f
+incdir+src
src/bps_pkg.sv
src/bps_seq.sv
src/beep_pattern_sequencer.sv
src/bps_checker.sv
dv/beep_pattern_sequencer_check.sv
dv/beep_pattern_sequencer_test.sv
